FILE: design/wdeq_pkg.sv
// Shared types and constants for the wrapping deadline event queue.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps
package wdeq_pkg;

	localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
	localparam logic [31:0] WRAP_WINDOW = 32'h1000_0000;

	localparam logic [2:0] CMD_ADD_DELAY = 3'd0;
	localparam logic [2:0] CMD_ADD_AT    = 3'd1;
	localparam logic [2:0] CMD_POP       = 3'd2;
	localparam logic [2:0] CMD_FIND      = 3'd3;
	localparam logic [2:0] CMD_DELETE    = 3'd4;
	localparam logic [2:0] CMD_REBASE    = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	localparam logic REG_SPECIAL = 1'b0;
	localparam logic REG_COMPARE = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE_TYPE,
		OP_REMOVE_FRONT,
		OP_MAP,
		OP_CLEAR,
		OP_FIND
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [3:0]  etype;
		logic [31:0] deadline;
		logic [31:0] now;
		logic [31:0] base;
		logic [3:0]  spec_type;
		logic        done;
	} op_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  etype;
		logic [31:0] deadline;
	} entry_t;

endpackage

FILE: design/wdeq_if.sv
// Handshake channel interfaces for the command and result words.
// Depends on nothing; the result channel width follows the queue depth.
`timescale 1ns / 1ps
interface wdeq_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [3:0]  event_type;
	logic [31:0] time_value;
	logic [31:0] compare_value;
	logic [31:0] current_count;
	modport source (output valid, command, event_type, time_value, compare_value,
		current_count, input ready);
	modport sink (input valid, command, event_type, time_value, compare_value,
		current_count, output ready);
endinterface

interface wdeq_out_if #(parameter int OCC_W = 5);
	logic             valid;
	logic             ready;
	logic [31:0]      next_deadline;
	logic [31:0]      found_deadline;
	logic [3:0]       front_type;
	logic [OCC_W-1:0] occupancy;
	logic             duplicate_seen;
	logic             overflow;
	modport source (output valid, next_deadline, found_deadline, front_type, occupancy,
		duplicate_seen, overflow, input ready);
	modport sink (input valid, next_deadline, found_deadline, front_type, occupancy,
		duplicate_seen, overflow, output ready);
endinterface

FILE: design/wdeq_cell.sv
// One queue slot: holds an event and trades it with its neighbors.
// Depends on wdeq_pkg for the operation and entry types.
`timescale 1ns / 1ps
module wdeq_cell import wdeq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  op_t    op,
	input  entry_t left,
	input  entry_t right,
	input  logic   g_in,
	input  logic   b_in,
	output entry_t cur,
	output logic   g_out,
	output logic   b_out,
	output logic   tmatch,
	output logic   sel
);

	entry_t      ent_q;
	entry_t      ent_d;
	logic [31:0] ad;
	logic [31:0] bd;
	logic [31:0] back;
	logic        gb;
	logic        special;
	logic        hit;

	assign cur = ent_q;

	always_comb begin
		ad = op.deadline - op.now;
		bd = ent_q.deadline - op.now;
		back = op.now - ent_q.deadline;
		if (ad[31]) begin
			gb = 1'b0;
		end else if (!bd[31]) begin
			gb = ad < bd;
		end else if (back < WRAP_WINDOW) begin
			gb = (ent_q.etype == op.spec_type) && op.done;
		end else begin
			gb = 1'b1;
		end
		special = op.etype == op.spec_type;
		tmatch = ent_q.valid && (ent_q.etype == op.etype);
		g_out = g_in || (ent_q.valid && gb && !special);
		case (op.kind)
			OP_INSERT:       hit = !ent_q.valid || (g_out && (ent_q.deadline != op.deadline));
			OP_REMOVE_TYPE:  hit = tmatch;
			OP_REMOVE_FRONT: hit = ent_q.valid;
			OP_FIND:         hit = tmatch;
			default:         hit = 1'b0;
		endcase
		b_out = b_in || hit;
		sel = hit && !b_in;
		ent_d = ent_q;
		case (op.kind)
			OP_INSERT: begin
				if (b_in) begin
					ent_d = left;
				end else if (hit) begin
					ent_d = '{valid: 1'b1, etype: op.etype, deadline: op.deadline};
				end
			end
			OP_REMOVE_TYPE, OP_REMOVE_FRONT: begin
				if (b_out) begin
					ent_d = right;
				end
			end
			OP_MAP: begin
				ent_d.deadline = (ent_q.deadline - op.now) + op.base;
			end
			OP_CLEAR: begin
				ent_d.valid = 1'b0;
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

FILE: design/wrapping_deadline_event_queue_unit.sv
// Top level of the wrapping deadline event queue: command sequencer and cell row.
// Depends on wdeq_pkg, wdeq_if and wdeq_cell.
//
//   channel   direction  handshake       contents
//   in_ch     in         valid/ready     command, type, time, compare, count
//   out_ch    out        valid/ready     next, found, front type, occupancy, flags
//   cfg       in         cfg_we          special and compare type codes
//
// The sequencer issues one operation to the row per cycle: a find, delete, clear, unused
// code or empty pop runs execute then finish; an add or pop has a hold state between.
// A new word is taken only in the idle state; the result register waits for ready.
// Reset empties the queue, sets the done flag and zeroes the held deadline.
`timescale 1ns / 1ps
module wrapping_deadline_event_queue_unit import wdeq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	wdeq_in_if.sink    in_ch,
	wdeq_out_if.source out_ch
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_DEL2, ST_MAP, ST_ADDC, ST_ADDS, ST_HOLD, ST_HOLDP, ST_FIN
	} state_t;

	state_t           state_q;
	logic [3:0]       spec_q;
	logic [3:0]       cmpt_q;
	logic [2:0]       cmd_q;
	logic [3:0]       type_q;
	logic [31:0]      tv_q;
	logic [31:0]      cv_q;
	logic [31:0]      now_q;
	logic [OCC_W-1:0] count_q;
	logic             done_q;
	logic [31:0]      held_q;
	logic [31:0]      found_q;
	logic             dup_q;
	logic             ovf_q;
	logic             ins_q;
	logic             out_valid_q;
	logic [31:0]      o_next_q;
	logic [31:0]      o_found_q;
	logic [3:0]       o_front_q;
	logic [OCC_W-1:0] o_occ_q;
	logic             o_dup_q;
	logic             o_ovf_q;

	op_t                    op;
	entry_t                 ent  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]   g;
	logic [QUEUE_DEPTH:0]   b;
	logic [QUEUE_DEPTH-1:0] tm;
	logic [QUEUE_DEPTH-1:0] sl;
	logic [QUEUE_DEPTH-1:0] vld;
	logic [31:0]            found_c;
	logic                   full;
	logic                   late;
	logic                   is_add;
	logic [31:0]            ins_d;

	assign g[0] = 1'b0;
	assign b[0] = 1'b0;
	assign full = count_q == OCC_W'(QUEUE_DEPTH);
	assign late = now_q > HALF_RANGE;
	assign is_add = (state_q == ST_EXEC && (cmd_q == CMD_ADD_DELAY || cmd_q == CMD_ADD_AT))
		|| state_q == ST_ADDC || state_q == ST_ADDS;

	always_comb begin
		case (state_q)
			ST_ADDC: ins_d = cv_q;
			ST_ADDS: ins_d = '0;
			default: ins_d = (cmd_q == CMD_ADD_DELAY) ? now_q + tv_q : tv_q;
		endcase
		op.etype = type_q;
		op.deadline = ins_d;
		op.now = now_q;
		op.base = tv_q;
		op.spec_type = spec_q;
		op.done = done_q && !late;
		op.kind = OP_NONE;
		case (state_q)
			ST_EXEC: begin
				case (cmd_q)
					CMD_ADD_DELAY, CMD_ADD_AT: op.kind = full ? OP_NONE : OP_INSERT;
					CMD_POP:    op.kind = (count_q != '0) ? OP_REMOVE_FRONT : OP_NONE;
					CMD_FIND:   op.kind = OP_FIND;
					CMD_DELETE: op.kind = OP_REMOVE_TYPE;
					CMD_REBASE: begin
						op.kind = OP_REMOVE_TYPE;
						op.etype = cmpt_q;
					end
					CMD_CLEAR:  op.kind = OP_CLEAR;
					default:    op.kind = OP_NONE;
				endcase
			end
			ST_DEL2: begin
				op.kind = OP_REMOVE_TYPE;
				op.etype = spec_q;
			end
			ST_MAP: op.kind = OP_MAP;
			ST_ADDC: begin
				op.kind = full ? OP_NONE : OP_INSERT;
				op.etype = cmpt_q;
			end
			ST_ADDS: begin
				op.kind = full ? OP_NONE : OP_INSERT;
				op.etype = spec_q;
			end
			default: op.kind = OP_NONE;
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t lft;
		entry_t rgt;
		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid
			assign lft = ent[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_body
			assign rgt = ent[i+1];
		end
		wdeq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (lft),
			.right  (rgt),
			.g_in   (g[i]),
			.b_in   (b[i]),
			.cur    (ent[i]),
			.g_out  (g[i+1]),
			.b_out  (b[i+1]),
			.tmatch (tm[i]),
			.sel    (sl[i])
		);
		assign vld[i] = ent[i].valid;
	end

	always_comb begin
		found_c = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			found_c = found_c | (sl[k] ? ent[k].deadline : 32'd0);
		end
	end

	assign in_ch.ready = state_q == ST_IDLE;
	assign out_ch.valid = out_valid_q;
	assign out_ch.next_deadline = o_next_q;
	assign out_ch.found_deadline = o_found_q;
	assign out_ch.front_type = o_front_q;
	assign out_ch.occupancy = o_occ_q;
	assign out_ch.duplicate_seen = o_dup_q;
	assign out_ch.overflow = o_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_q <= 4'd0;
			cmpt_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPECIAL: spec_q <= cfg_data;
				REG_COMPARE: cmpt_q <= cfg_data;
				default:     spec_q <= spec_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q <= in_ch.command;
			type_q <= in_ch.event_type;
			tv_q <= in_ch.time_value;
			cv_q <= in_ch.compare_value;
			now_q <= in_ch.current_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q <= 1'b1;
			held_q <= '0;
			found_q <= '0;
			dup_q <= 1'b0;
			ovf_q <= 1'b0;
			ins_q <= 1'b0;
			out_valid_q <= 1'b0;
			o_next_q <= '0;
			o_found_q <= '0;
			o_front_q <= '0;
			o_occ_q <= '0;
			o_dup_q <= 1'b0;
			o_ovf_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			ins_q <= op.kind == OP_INSERT;
			if (ins_q) begin
				held_q <= ent[0].deadline;
			end
			if (is_add) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					if (|tm) begin
						dup_q <= 1'b1;
					end
					if (late) begin
						done_q <= 1'b0;
					end
					count_q <= count_q + 1'b1;
				end
			end
			if ((op.kind == OP_REMOVE_TYPE || op.kind == OP_REMOVE_FRONT) && b[QUEUE_DEPTH]) begin
				count_q <= count_q - 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_EXEC;
						found_q <= '0;
						dup_q <= 1'b0;
						ovf_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					case (cmd_q)
						CMD_ADD_DELAY, CMD_ADD_AT: state_q <= ST_HOLD;
						CMD_POP: begin
							if (count_q != '0) begin
								if (ent[0].etype == spec_q) begin
									done_q <= 1'b1;
								end
								state_q <= ST_HOLDP;
							end else begin
								state_q <= ST_FIN;
							end
						end
						CMD_FIND: begin
							found_q <= found_c;
							state_q <= ST_FIN;
						end
						CMD_REBASE: state_q <= ST_DEL2;
						CMD_CLEAR: begin
							count_q <= '0;
							held_q <= '0;
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_DEL2: state_q <= ST_MAP;
				ST_MAP:  state_q <= ST_ADDC;
				ST_ADDC: state_q <= ST_ADDS;
				ST_ADDS: state_q <= ST_HOLD;
				ST_HOLD: state_q <= ST_FIN;
				ST_HOLDP: begin
					if (ent[0].valid && (ent[0].deadline > now_q
						|| (now_q - ent[0].deadline) < HALF_RANGE)) begin
						held_q <= ent[0].deadline;
					end else begin
						held_q <= '0;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						o_next_q <= held_q;
						o_found_q <= found_q;
						o_front_q <= (count_q != '0) ? ent[0].etype : 4'd0;
						o_occ_q <= count_q;
						o_dup_q <= dup_q;
						o_ovf_q <= ovf_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == OCC_W'($countones(vld)))
		else $error("occupancy differs from the number of filled cells");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(is_add && full) |=> ovf_q)
		else $error("dropped insert not flagged");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(op.kind == OP_CLEAR) |=> (count_q == '0 && held_q == '0))
		else $error("clear left events behind");

endmodule
